@@ rtl/kivt_pkg.sv @@
// ----------------------------------------------------------------------------
// kivt_pkg
// Types and fixed constants for the key indexed voice table.
// ----------------------------------------------------------------------------
package kivt_pkg;

	// Request kinds carried on s_tuser
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STOP  = 1'b1;

	// Field widths
	localparam int KEY_BITS  = 8;
	localparam int WORD_BITS = 32;
	localparam int SPAN_BITS = 8;
	localparam int ENTRY_BITS = 3 * WORD_BITS;

	// Packed stream widths
	localparam int IN_DATA_BITS  = KEY_BITS + ENTRY_BITS;             // 104
	localparam int OUT_DATA_BITS = KEY_BITS + ENTRY_BITS + SPAN_BITS; // 112

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_SPAN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

@@ rtl/key_indexed_voice_table_core.sv @@
// ----------------------------------------------------------------------------
// key_indexed_voice_table_core
// One voice entry per key: start and stop requests in, release reports out.
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE and then steps through ST_READ, ST_EXEC,
// ST_SPAN when a stop releases the top entry and the span has to be searched
// down again, and ST_DONE, where its result is loaded into the output register
// once that register is free. The sequence is set by the read-modify-write of
// the entry memory (read, then update and write back) and by the priority
// encoder over the valid bits that recomputes the span. One request is in
// work at a time; the result register lets the next request be accepted while
// a finished result still waits on m_tready. Valid bits are cleared by reset
// at once, there is no clearing pass.
module key_indexed_voice_table_core
	import kivt_pkg::*;
#(
	parameter int KEY_SLOTS = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// s_tdata, lowest bit up: key[7:0], phase_step[31:0], start_phase[31:0],
	// velocity[31:0]
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// s_tuser: req_type (0 start, 1 stop)
	input  logic                     s_tuser,
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// m_tdata, lowest bit up: released_key[7:0], released_step[31:0],
	// released_phase[31:0], released_velocity[31:0], active_span[7:0]
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// m_tuser: released
	output logic                     m_tuser
);

	localparam int KEY_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int SPAN_W = $clog2(KEY_SLOTS + 1);
	localparam logic [KEY_BITS:0] SLOTS_EXT = (KEY_BITS + 1)'(KEY_SLOTS);

	state_t state_q;

	// request registers
	logic                  stop_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [ENTRY_BITS-1:0] words_q;
	logic                  in_range_q;
	logic [KEY_W-1:0]      idx;

	// entry state
	logic [ENTRY_BITS-1:0] words_mem [KEY_SLOTS];
	logic [ENTRY_BITS-1:0] rd_words_s1;
	logic [KEY_SLOTS-1:0]  valid_q;
	logic [SPAN_W-1:0]     span_q;
	logic [SPAN_W-1:0]     top_span;

	// result of the request in work
	logic                  rel_q;
	logic [ENTRY_BITS-1:0] rel_words_q;

	// output register
	logic                     out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic                     out_user_q;

	logic s_accept;
	logic hit;
	logic key_above_span;
	logic key_is_top;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign idx      = key_q[KEY_W-1:0];
	assign hit      = in_range_q && valid_q[idx];
	assign key_above_span = ((KEY_BITS + 1)'(key_q)) >= ((KEY_BITS + 1)'(span_q));
	assign key_is_top     = ((KEY_BITS + 1)'(key_q) + (KEY_BITS + 1)'(1))
	                        == ((KEY_BITS + 1)'(span_q));
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Find one above the highest valid entry
	always_comb begin
		top_span = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (valid_q[i]) begin
				top_span = SPAN_W'(i + 1);
			end
		end
	end

	// Entry memory: read in ST_READ, write back in ST_EXEC
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_words_s1 <= words_mem[idx];
		end
		if (state_q == ST_EXEC && in_range_q && stop_q == REQ_START) begin
			words_mem[idx] <= words_q;
		end
	end

	// Latch the request on acceptance
	always_ff @(posedge clk) begin
		if (s_accept) begin
			stop_q     <= s_tuser;
			key_q      <= s_tdata[KEY_BITS-1:0];
			words_q    <= s_tdata[IN_DATA_BITS-1:KEY_BITS];
			in_range_q <= ((KEY_BITS + 1)'(s_tdata[KEY_BITS-1:0])) < SLOTS_EXT;
		end
		if (state_q == ST_EXEC) begin
			rel_words_q <= hit ? rd_words_s1 : '0;
		end
	end

	// Sequence the request and update valid bits and span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			span_q  <= '0;
			rel_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					rel_q   <= hit;
					state_q <= ST_DONE;
					if (in_range_q) begin
						if (stop_q == REQ_START) begin
							valid_q[idx] <= 1'b1;
							if (key_above_span) begin
								span_q <= SPAN_W'(key_q) + SPAN_W'(1);
							end
						end else if (valid_q[idx]) begin
							valid_q[idx] <= 1'b0;
							if (key_is_top) begin
								state_q <= ST_SPAN;
							end
						end
					end
				end
				ST_SPAN: begin
					span_q  <= top_span;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hand the result to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_user_q <= rel_q;
			out_data_q <= {SPAN_BITS'(span_q), rel_words_q,
			               rel_q ? key_q : {KEY_BITS{1'b0}}};
		end
	end

	// Span always sits one above the highest valid entry between requests
	a_span_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (span_q == top_span))
		else $error("span does not match valid bits");

	// A start on a key in the table leaves its entry valid
	a_start_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && in_range_q && stop_q == REQ_START) |-> valid_q[idx])
		else $error("start did not mark entry valid");

	// A stop that released leaves its entry invalid
	a_stop_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && stop_q == REQ_STOP && rel_q) |-> !valid_q[idx])
		else $error("stop did not clear entry");

	// A result without a release carries zero entry fields
	a_no_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[KEY_BITS+ENTRY_BITS-1:0] == '0))
		else $error("unreleased result carries entry data");

	// Accepting a request always starts the memory read next
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_READ))
		else $error("accepted request did not start read");

endmodule

@@ tb/key_indexed_voice_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_indexed_voice_table_core_tb
// Start and stop requests go in over the request stream, and every result is
// checked against a local voice table. That table holds the valid marks, the
// stored words and the span. A directed pass covers the key and word
// extremes, releases on restart and on stop, stops on empty entries, keys
// beyond the table and the span falling back. A back-pressure pass then holds
// the result stream off long enough to stall the request stream. Random
// traffic on a rotating set of hot keys follows, mixed with stray keys.
// ----------------------------------------------------------------------------
module key_indexed_voice_table_core_tb;
	import kivt_pkg::*;

	localparam int KEY_SLOTS   = 128;
	localparam int SLOT_W      = $clog2(KEY_SLOTS);
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 750;

	typedef struct packed {
		logic                 released;
		logic [KEY_BITS-1:0]  key;
		logic [WORD_BITS-1:0] step;
		logic [WORD_BITS-1:0] phase;
		logic [WORD_BITS-1:0] velocity;
		logic [SPAN_BITS-1:0] span;
	} voice_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	// s_tdata, lowest bit up: key, phase_step, start_phase, velocity
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	// s_tuser: req_type
	logic                     s_tuser = REQ_START;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// m_tdata, lowest bit up: released_key, released_step, released_phase,
	// released_velocity, active_span
	logic [OUT_DATA_BITS-1:0] m_tdata;
	// m_tuser: released
	logic                     m_tuser;

	// Local copy of the voice table
	logic                 slot_live [KEY_SLOTS];
	logic [WORD_BITS-1:0] slot_step [KEY_SLOTS];
	logic [WORD_BITS-1:0] slot_phase [KEY_SLOTS];
	logic [WORD_BITS-1:0] slot_velocity [KEY_SLOTS];
	int unsigned          table_span;

	voice_report_t pending_reports [$];
	int            mismatch_count = 0;
	int            report_count = 0;
	int            idle_cycles = 0;

	// Receiver control
	int       hold_asked = 0;
	int       hold_served = 0;
	int       hold_left = 0;
	int       stall_mode = 0;
	logic [7:0] stall_phase = '0;

	key_indexed_voice_table_core #(
		.KEY_SLOTS(KEY_SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_step[i] = '0;
			slot_phase[i] = '0;
			slot_velocity[i] = '0;
		end
		table_span = 0;
	end

	// Apply one request to the local table and return the report it causes
	function automatic voice_report_t apply_voice_request(input logic kind,
			input logic [KEY_BITS-1:0] key, input logic [WORD_BITS-1:0] step,
			input logic [WORD_BITS-1:0] phase, input logic [WORD_BITS-1:0] velocity);
		voice_report_t     rep;
		int unsigned       s;
		logic [SLOT_W-1:0] slot;
		rep = '0;
		slot = key[SLOT_W-1:0];
		if (int'(key) < KEY_SLOTS) begin
			if (kind == REQ_START) begin
				if (32'(key) >= table_span)
					table_span = 32'(key) + 1;
				if (slot_live[slot]) begin
					rep.released = 1'b1;
					rep.key = key;
					rep.step = slot_step[slot];
					rep.phase = slot_phase[slot];
					rep.velocity = slot_velocity[slot];
				end
				slot_step[slot] = step;
				slot_phase[slot] = phase;
				slot_velocity[slot] = velocity;
				slot_live[slot] = 1'b1;
			end else if (slot_live[slot]) begin
				rep.released = 1'b1;
				rep.key = key;
				rep.step = slot_step[slot];
				rep.phase = slot_phase[slot];
				rep.velocity = slot_velocity[slot];
				slot_live[slot] = 1'b0;
				// search the span down when the top entry goes away
				if (32'(key) + 1 == table_span) begin
					s = 32'(key);
					while (s > 0 && !slot_live[SLOT_W'(s - 1)])
						s--;
					table_span = s;
				end
			end
		end
		rep.span = table_span[SPAN_BITS-1:0];
		return rep;
	endfunction

	// Offer one request and hold it until accepted; leave tvalid high
	task automatic send_voice_request(input logic kind, input logic [KEY_BITS-1:0] key,
			input logic [WORD_BITS-1:0] step, input logic [WORD_BITS-1:0] phase,
			input logic [WORD_BITS-1:0] velocity);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {velocity, phase, step, key};
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(apply_voice_request(kind, key, step, phase, velocity));
	endtask

	// Drop tvalid for a number of cycles
	task automatic sender_gap(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [WORD_BITS-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed_cases();
		send_voice_request(REQ_STOP,  8'd5,   32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
		send_voice_request(REQ_START, 8'd0,   '0, '0, '0);
		send_voice_request(REQ_START, 8'd0,   '1, '1, '1);
		send_voice_request(REQ_START, 8'd127, '1, '1, '1);
		send_voice_request(REQ_START, 8'd64,  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send_voice_request(REQ_START, 8'd127, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		send_voice_request(REQ_STOP,  8'd127, '0, '0, '0);
		send_voice_request(REQ_STOP,  8'd127, '1, '1, '1);
		send_voice_request(REQ_START, 8'd128, '1, '1, '1);
		send_voice_request(REQ_STOP,  8'd255, '1, '1, '1);
		send_voice_request(REQ_START, 8'd255, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
		send_voice_request(REQ_STOP,  8'd64,  '0, '0, '0);
		send_voice_request(REQ_STOP,  8'd0,   '0, '0, '0);
		send_voice_request(REQ_START, 8'd1,   32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_F00D);
		send_voice_request(REQ_START, 8'd3,   32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_FF00);
		// stop below the top leaves the span alone
		send_voice_request(REQ_STOP,  8'd1,   '0, '0, '0);
		send_voice_request(REQ_STOP,  8'd3,   '0, '0, '0);
		send_voice_request(REQ_STOP,  8'd3,   '0, '0, '0);
		send_voice_request(REQ_START, 8'd126, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
		send_voice_request(REQ_START, 8'd127, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE);
		send_voice_request(REQ_STOP,  8'd126, '0, '0, '0);
		send_voice_request(REQ_STOP,  8'd127, '0, '0, '0);
	endtask

	// Hold the result stream off while requests keep coming
	task automatic test_result_backpressure();
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 12; i++)
			send_voice_request(REQ_START, 8'(10 + i), random_word(), random_word(),
				random_word());
		for (int i = 0; i < 12; i++)
			send_voice_request(REQ_STOP, 8'(21 - i), '0, '0, '0);
		sender_gap(4);
	endtask

	task automatic test_random_traffic(input int count);
		logic [KEY_BITS-1:0] hot_keys [8];
		logic [KEY_BITS-1:0] key;
		logic                kind;
		int                  sent;
		int                  burst;
		int                  gap;
		for (int i = 0; i < 8; i++)
			hot_keys[i] = 8'($urandom_range(0, KEY_SLOTS - 1));
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
			if (burst > count - sent)
				burst = count - sent;
			repeat (burst) begin
				// rotate the hot set now and then, favoring the table ends
				if ($urandom_range(0, 15) == 0) begin
					case ($urandom_range(0, 5))
						0: hot_keys[$urandom_range(0, 7)] = 8'd0;
						1: hot_keys[$urandom_range(0, 7)] = 8'(KEY_SLOTS - 1);
						default: hot_keys[$urandom_range(0, 7)] =
							8'($urandom_range(0, KEY_SLOTS - 1));
					endcase
				end
				case ($urandom_range(0, 11))
					0: key = 8'($urandom_range(KEY_SLOTS, 255));
					1, 2, 3: key = 8'($urandom_range(0, KEY_SLOTS - 1));
					default: key = hot_keys[$urandom_range(0, 7)];
				endcase
				kind = ($urandom_range(0, 99) < 55) ? REQ_START : REQ_STOP;
				send_voice_request(kind, key, random_word(), random_word(), random_word());
				sent++;
			end
			gap = $urandom_range(0, 12);
			if (gap != 0)
				sender_gap(gap);
		end
	endtask

	task automatic check_field(input string name, input logic [WORD_BITS-1:0] want,
			input logic [WORD_BITS-1:0] got);
		if (want !== got) begin
			if (mismatch_count < 10)
				$display("result %0d: %s expected %h, got %h", report_count, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each accepted result with the oldest expected report
	always @(posedge clk) begin
		voice_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				if (mismatch_count < 10)
					$display("result %0d: unexpected, data %h released %b",
						report_count, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("released", 32'(want.released), 32'(m_tuser));
				check_field("released_key", 32'(want.key), 32'(m_tdata[7:0]));
				check_field("released_step", want.step, m_tdata[39:8]);
				check_field("released_phase", want.phase, m_tdata[71:40]);
				check_field("released_velocity", want.velocity, m_tdata[103:72]);
				check_field("active_span", 32'(want.span), 32'(m_tdata[111:104]));
			end
			report_count++;
		end
	end

	// Drive tready: long hold when asked, else a stall mode that rotates
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (stall_phase[1:0] == 2'b00);
				default: m_tready <= ($urandom_range(0, 4) != 0);
			endcase
		end
		stall_phase <= stall_phase + 8'd1;
		if (stall_phase[5:0] == 6'd63)
			stall_mode <= int'($urandom_range(0, 3));
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_result_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
